@@ rtl/iirlp6_pkg.sv @@
package iirlp6_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 12;
   localparam int COEF_FRAC_DEFAULT    = 28;

   localparam int OFFSET_WIDTH = 12;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_RESET = 12'd2048;

   localparam int NTAP      = 6;
   localparam int FF_TAPS   = NTAP + 1;
   localparam int Y_WIDTH   = 40;
   localparam int Y_FRAC    = 16;
   localparam int OUT_WIDTH = 14;
   localparam int ACC_WIDTH = 48;

   // second multiplier operand: high part of y, low part of y, or a sample
   localparam int OPB_WIDTH = Y_WIDTH - Y_FRAC + 1;

   // one multiply per feed-forward tap, two per feedback tap
   localparam int STEP_COUNT = FF_TAPS + 2 * NTAP;
   localparam int STEP_WIDTH = $clog2(STEP_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      TERM_NONE,
      TERM_FF,
      TERM_FB_LO,
      TERM_FB_HI
   } term_type;

   typedef logic [0:FF_TAPS-1][63:0] ff_tab_type;
   typedef logic [0:NTAP-1][63:0]    fb_tab_type;

   // coefficients in Q30
   localparam ff_tab_type FF_Q30 = '{
      64'sd502651, 64'sd3015905, 64'sd7539763, 64'sd10053018,
      64'sd7539763, 64'sd3015905, 64'sd502651
   };
   localparam fb_tab_type FB_Q30 = '{
      -64'sd3677053293, 64'sd5623782704, -64'sd4800591501,
      64'sd2388637885, -64'sd652429453, 64'sd76081491
   };

   // round half up from Q30 to the chosen fraction width
   function automatic logic signed [63:0] coef_round(logic signed [63:0] q30, int frac);
      int d;
      d = 30 - frac;
      if (d == 0) begin
         return q30;
      end
      return (q30 + (64'sd1 <<< (d - 1))) >>> d;
   endfunction

   function automatic ff_tab_type ff_coefs(int frac);
      ff_tab_type t;
      for (int i = 0; i < FF_TAPS; i++) begin
         t[i] = coef_round($signed(FF_Q30[i]), frac);
      end
      return t;
   endfunction

   function automatic fb_tab_type fb_coefs(int frac);
      fb_tab_type t;
      for (int i = 0; i < NTAP; i++) begin
         t[i] = coef_round($signed(FB_Q30[i]), frac);
      end
      return t;
   endfunction

endpackage

@@ rtl/iir_lowpass_order6_direct_form1.sv @@
// A sample word is accepted only while idle; it then runs through the one shared
// multiplier (one pass per feed-forward tap, two per feedback tap), a drain step and
// a write-back step that makes the result word valid; no new sample is taken before that.
// A finished word waits in the output register; the next sample is taken meanwhile.
// Reset (synchronous, active high): histories cleared, offset back to mid-scale,
// no word pending.
module iir_lowpass_order6_direct_form1 #(
   parameter int SAMPLE_WIDTH       = iirlp6_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_FRACTION_BITS = iirlp6_pkg::COEF_FRAC_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [SAMPLE_WIDTH-1:0]                req_adc_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [iirlp6_pkg::OUT_WIDTH-1:0] rsp_filtered_sample,
   input  logic                                   csr_wr_en,
   input  logic [iirlp6_pkg::OFFSET_WIDTH-1:0]    csr_wr_data
);

   localparam int OW    = iirlp6_pkg::OFFSET_WIDTH;
   localparam int XW    = ((SAMPLE_WIDTH > OW) ? SAMPLE_WIDTH : OW) + 1;
   localparam int CW    = COEF_FRACTION_BITS + 4;
   localparam int BW    = iirlp6_pkg::OPB_WIDTH;
   localparam int PW    = CW + BW;
   localparam int PSW   = PW + 1;
   localparam int ACC_W = iirlp6_pkg::ACC_WIDTH;
   localparam int Y_W   = iirlp6_pkg::Y_WIDTH;
   localparam int Y_F   = iirlp6_pkg::Y_FRAC;
   localparam int OUT_W = iirlp6_pkg::OUT_WIDTH;
   localparam int NTAP  = iirlp6_pkg::NTAP;
   localparam int SH    = COEF_FRACTION_BITS - Y_F;
   localparam int STW   = iirlp6_pkg::STEP_WIDTH;

   localparam logic [STW-1:0] LAST_STEP = STW'(iirlp6_pkg::STEP_COUNT - 1);
   localparam logic [STW-1:0] FF_STEPS  = STW'(iirlp6_pkg::FF_TAPS);

   localparam iirlp6_pkg::ff_tab_type FF_COEF = iirlp6_pkg::ff_coefs(COEF_FRACTION_BITS);
   localparam iirlp6_pkg::fb_tab_type FB_COEF = iirlp6_pkg::fb_coefs(COEF_FRACTION_BITS);

   localparam logic signed [ACC_W-1:0] Y_HI = {{(ACC_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_LO = {{(ACC_W-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}};
   localparam logic signed [Y_W:0]     RND  = (Y_W+1)'(1) <<< (Y_F - 1);
   localparam logic signed [Y_W:0]     R_HI = {{(Y_W-OUT_W+2){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [Y_W:0]     R_LO = {{(Y_W-OUT_W+2){1'b1}}, {(OUT_W-1){1'b0}}};

   iirlp6_pkg::state_type state_ff, state_in;
   iirlp6_pkg::term_type  tag_ff, tag_in;
   logic [STW-1:0]        step_ff, step_in;
   logic [OW-1:0]         offset_ff, offset_in;
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [XW-1:0]  xh_ff [NTAP];
   logic signed [XW-1:0]  xh_in [NTAP];
   logic signed [Y_W-1:0] yh_ff [NTAP];
   logic signed [Y_W-1:0] yh_in [NTAP];
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [PW-1:0]  bh_ff, bh_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  ff_sel;
   logic [2:0]            ff_idx;
   logic [STW-1:0]        fb_j;
   logic [2:0]            fb_idx;
   logic signed [XW-1:0]  x_tap;
   logic signed [Y_W-1:0] y_tap;
   logic signed [CW-1:0]  coef_sel;
   logic signed [BW-1:0]  opb_sel;
   logic signed [XW-1:0]  x_new;
   logic signed [ACC_W-1:0] ff_term;
   logic signed [PSW-1:0] fb_sum;
   logic signed [ACC_W-1:0] fb_term;
   logic signed [Y_W-1:0] y_sat;
   logic signed [Y_W:0]   y_round;
   logic signed [Y_W:0]   r_full;
   logic signed [OUT_W-1:0] out_sat;

   assign req_ready           = (state_ff == iirlp6_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_data_ff;

   // operand selection for the shared multiplier
   always_comb begin
      ff_sel = (step_ff < FF_STEPS);
      ff_idx = step_ff[2:0];
      fb_j   = step_ff - FF_STEPS;
      fb_idx = fb_j[3:1];
      x_tap  = (ff_idx == 3'd0) ? x_ff : xh_ff[ff_idx - 3'd1];
      y_tap  = yh_ff[fb_idx];
      if (ff_sel) begin
         coef_sel = CW'(FF_COEF[ff_idx]);
         opb_sel  = BW'(x_tap);
      end else begin
         coef_sel = CW'(FB_COEF[fb_idx]);
         if (fb_j[0]) begin
            opb_sel = BW'($signed(y_tap[Y_W-1:Y_F]));
         end else begin
            opb_sel = $signed(BW'(y_tap[Y_F-1:0]));
         end
      end
   end

   always_comb begin
      x_new   = $signed(XW'(req_adc_sample)) - $signed(XW'(offset_ff));
      ff_term = ACC_W'(prod_ff >>> SH);
      fb_sum  = PSW'(prod_ff) + PSW'(bh_ff);
      fb_term = ACC_W'(fb_sum >>> SH);

      if (acc_ff > Y_HI) begin
         y_sat = Y_W'(Y_HI);
      end else if (acc_ff < Y_LO) begin
         y_sat = Y_W'(Y_LO);
      end else begin
         y_sat = Y_W'(acc_ff);
      end
      y_round = (Y_W+1)'(y_sat) + RND;
      r_full  = y_round >>> Y_F;
      if (r_full > R_HI) begin
         out_sat = OUT_W'(R_HI);
      end else if (r_full < R_LO) begin
         out_sat = OUT_W'(R_LO);
      end else begin
         out_sat = OUT_W'(r_full);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      tag_in       = iirlp6_pkg::TERM_NONE;
      offset_in    = csr_wr_en ? csr_wr_data : offset_ff;
      x_in         = x_ff;
      xh_in        = xh_ff;
      yh_in        = yh_ff;
      prod_in      = coef_sel * opb_sel;
      bh_in        = bh_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // fold in the product issued last cycle: accumulate it, or hold a feedback low half
      case (tag_ff)
         iirlp6_pkg::TERM_FF: begin
            acc_in = acc_ff + ff_term;
         end
         iirlp6_pkg::TERM_FB_LO: begin
            bh_in = prod_ff >>> Y_F;
         end
         iirlp6_pkg::TERM_FB_HI: begin
            acc_in = acc_ff - fb_term;
         end
         default: begin
         end
      endcase

      case (state_ff)
         iirlp6_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in     = x_new;
               acc_in   = '0;
               step_in  = '0;
               state_in = iirlp6_pkg::ST_RUN;
            end
         end
         iirlp6_pkg::ST_RUN: begin
            if (ff_sel) begin
               tag_in = iirlp6_pkg::TERM_FF;
            end else if (fb_j[0]) begin
               tag_in = iirlp6_pkg::TERM_FB_HI;
            end else begin
               tag_in = iirlp6_pkg::TERM_FB_LO;
            end
            if (step_ff == LAST_STEP) begin
               state_in = iirlp6_pkg::ST_DRAIN;
            end else begin
               step_in = step_ff + STW'(1);
            end
         end
         iirlp6_pkg::ST_DRAIN: begin
            state_in = iirlp6_pkg::ST_WRITE;
         end
         iirlp6_pkg::ST_WRITE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               for (int k = NTAP - 1; k > 0; k--) begin
                  xh_in[k] = xh_ff[k-1];
                  yh_in[k] = yh_ff[k-1];
               end
               xh_in[0]     = x_ff;
               yh_in[0]     = y_sat;
               rsp_data_in  = out_sat;
               rsp_valid_in = 1'b1;
               state_in     = iirlp6_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iirlp6_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iirlp6_pkg::ST_IDLE;
         tag_ff       <= iirlp6_pkg::TERM_NONE;
         step_ff      <= '0;
         offset_ff    <= iirlp6_pkg::OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NTAP; k++) begin
            xh_ff[k] <= '0;
            yh_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         step_ff      <= step_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
         xh_ff        <= xh_in;
         yh_ff        <= yh_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      bh_ff       <= bh_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= LAST_STEP)
      else $error("step counter beyond last tap");

   a_fb_pair: assert property (@(posedge clock) disable iff (reset)
      tag_ff == iirlp6_pkg::TERM_FB_HI |-> $past(tag_ff) == iirlp6_pkg::TERM_FB_LO)
      else $error("feedback high half without its low half");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == iirlp6_pkg::ST_RUN && step_ff == '0
         && acc_ff == '0)
      else $error("accepted word did not start a clean pass");

   a_write_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == iirlp6_pkg::ST_WRITE && rsp_valid && !rsp_ready
         |=> state_ff == iirlp6_pkg::ST_WRITE && $stable(acc_ff))
      else $error("result overwrote a pending word");

endmodule
